[design/atp_pkg.sv]
// Shared types and constants for the audio transport stream packetiser.
// Used by every module of the block; depends on nothing.
package atp_pkg;

    localparam int ATP_QUEUE_DEPTH = 4;

    localparam int PID_W      = 13;
    localparam int FLEN_W     = 13;
    localparam int TS_MS_W    = 32;
    localparam int PTS_W      = 33;
    localparam int LEFT_W     = 14;
    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [POS_W-1:0] TS_PKT_LEN  = 8'd188;
    localparam logic [POS_W-1:0] TS_BODY_LEN = 8'd184;
    localparam logic [7:0] TS_SYNC     = 8'h47;
    localparam logic [7:0] PES_AUDIO_ID = 8'hc0;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PID         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODEC_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADTS_PROF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 3'd4;

    typedef enum logic [1:0] {
        KIND_DATA,   // payload byte alone
        KIND_HEAD,   // TS header (and stuffing) then payload byte
        KIND_START   // TS header, stuffing, PES header, ADTS header (AAC only), payload byte
    } kind_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic             codec_mode;
        logic [1:0]       adts_profile;
        logic [3:0]       sample_rate_index;
        logic [2:0]       channel_config;
    } cfg_t;

    // one burst of output bytes, as worked out by the front end
    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        logic [POS_W-1:0] stuff;
        logic [3:0]       cc;
        logic             aac;
        logic [15:0]      plen;
        logic [12:0]      fl;
        logic [PTS_W-1:0] pts;
        logic [POS_W-1:0] olen;
        logic             pkt_end;
    } desc_t;

endpackage

[design/atp_queue.sv]
// Small descriptor queue between the front end and the byte generator.
// Depends on atp_pkg for the descriptor type.
module atp_queue
    import atp_pkg::*;
#(
    parameter int DEPTH = ATP_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_data,
    input  logic  pop,
    output desc_t head,
    output logic  full,
    output logic  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/atp_front.sv]
// Front end: takes input items, keeps frame and packet position state and
// turns each item into a burst descriptor. Depends on atp_pkg.
module atp_front
    import atp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               codec_mode,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               frame_start,
    input  logic [FLEN_W-1:0]  frame_len,
    input  logic [TS_MS_W-1:0] timestamp_ms,
    input  logic               queue_full,
    output logic               push,
    output desc_t              desc
);

    logic [3:0]        continuity_reg, continuity_next;
    logic [LEFT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [POS_W-1:0]  packet_pos_reg, packet_pos_next;

    logic              accepted, idle_frame, aac;
    logic [FLEN_W-1:0] flen_eff;
    logic [LEFT_W-1:0] total;
    logic [POS_W-1:0]  start_stuff, start_olen, head_stuff, head_olen;
    logic [PTS_W-1:0]  ts33, pts;
    logic [POS_W:0]    pos_sum;

    assign in_ready   = !queue_full;
    assign accepted   = in_valid && in_ready;
    assign idle_frame = (bytes_left_reg == '0);
    assign aac        = !codec_mode;
    assign flen_eff   = (frame_len == '0) ? FLEN_W'(1) : frame_len;
    assign total      = {1'b0, flen_eff} + (aac ? LEFT_W'(7) : LEFT_W'(0));
    assign start_stuff = (total < LEFT_W'(170)) ? POS_W'(LEFT_W'(170) - total) : '0;
    assign start_olen  = 8'd19 + start_stuff + (aac ? 8'd7 : 8'd0);
    assign head_stuff  = (bytes_left_reg < LEFT_W'(TS_BODY_LEN)) ?
                         POS_W'(LEFT_W'(TS_BODY_LEN) - bytes_left_reg) : '0;
    assign head_olen   = 8'd5 + head_stuff;

    // timestamp * 90 as shifts and adds, kept to 33 bits
    assign ts33 = {1'b0, timestamp_ms};
    assign pts  = (ts33 << 6) + (ts33 << 4) + (ts33 << 3) + (ts33 << 1);

    always_comb
    begin
        continuity_next = continuity_reg;
        bytes_left_next = bytes_left_reg;
        packet_pos_next = packet_pos_reg;
        push            = 1'b0;
        pos_sum         = '0;

        desc.kind    = KIND_DATA;
        desc.data    = data_byte;
        desc.stuff   = '0;
        desc.cc      = continuity_reg + 1'b1;
        desc.aac     = aac;
        desc.plen    = 16'(total) + 16'd8;
        desc.fl      = total[12:0];
        desc.pts     = pts;
        desc.olen    = 8'd1;
        desc.pkt_end = 1'b0;

        if (accepted && !(idle_frame && !frame_start))
        begin
            push = 1'b1;
            if (idle_frame)
            begin
                desc.kind       = KIND_START;
                desc.stuff      = start_stuff;
                desc.olen       = start_olen;
                continuity_next = continuity_reg + 1'b1;
                bytes_left_next = {1'b0, flen_eff} - 1'b1;
                pos_sum         = {1'b0, start_olen};
            end
            else
            begin
                if (packet_pos_reg == '0)
                begin
                    desc.kind       = KIND_HEAD;
                    desc.stuff      = head_stuff;
                    desc.olen       = head_olen;
                    continuity_next = continuity_reg + 1'b1;
                end
                bytes_left_next = bytes_left_reg - 1'b1;
                pos_sum         = {1'b0, packet_pos_reg} + {1'b0, desc.olen};
            end
            if (pos_sum >= {1'b0, TS_PKT_LEN})
            begin
                desc.pkt_end    = 1'b1;
                packet_pos_next = '0;
            end
            else
            begin
                packet_pos_next = pos_sum[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            continuity_reg <= 4'hf;
            bytes_left_reg <= '0;
            packet_pos_reg <= '0;
        end
        else
        begin
            continuity_reg <= continuity_next;
            bytes_left_reg <= bytes_left_next;
            packet_pos_reg <= packet_pos_next;
        end
    end

endmodule

[design/atp_back.sv]
// Back end: walks the burst at the queue head and emits up to eight bytes
// per word into the output register. Depends on atp_pkg.
module atp_back
    import atp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  desc_t       head,
    input  logic        head_valid,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_bytes,
    output logic [3:0]  byte_count,
    output logic        packet_end,
    output logic        last
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      bytes_reg, bytes_next;
    logic [3:0]       count_reg, count_next;
    logic             pkt_end_reg, pkt_end_next;
    logic             last_reg, last_next;

    logic             load, advance, fin;
    logic [POS_W-1:0] remaining;
    logic [3:0]       cnt;

    // byte at position idx of the burst described by d
    function automatic logic [7:0] burst_byte(input desc_t d, input logic [POS_W-1:0] idx,
                                              input cfg_t c);
        logic [POS_W-1:0] j;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] q;
        logic [7:0]       b;
        j = idx - 8'd4;
        p = idx - 8'd4 - d.stuff;
        q = p - 8'd14;
        b = 8'h00;
        if (d.kind == KIND_DATA || idx == d.olen - 1'b1)
        begin
            b = d.data;
        end
        else if (idx < 8'd4)
        begin
            case (idx[1:0])
                2'd0:    b = TS_SYNC;
                2'd1:    b = {1'b0, d.kind == KIND_START, 1'b0, c.pid[12:8]};
                2'd2:    b = c.pid[7:0];
                default: b = {2'b00, d.stuff != '0, 1'b1, d.cc};
            endcase
        end
        else if ({1'b0, idx} < 9'd4 + {1'b0, d.stuff})
        begin
            // adaptation field: length, flags, then 0xff fill
            if (j == '0)
                b = d.stuff - 1'b1;
            else if (j == 8'd1)
                b = 8'h00;
            else
                b = 8'hff;
        end
        else if (p < 8'd14)
        begin
            case (p)
                8'd2:    b = 8'h01;
                8'd3:    b = PES_AUDIO_ID;
                8'd4:    b = d.plen[15:8];
                8'd5:    b = d.plen[7:0];
                8'd6:    b = 8'h80;
                8'd7:    b = 8'h80;
                8'd8:    b = 8'h05;
                8'd9:    b = {4'h2, d.pts[32:30], 1'b1};
                8'd10:   b = d.pts[29:22];
                8'd11:   b = {d.pts[21:15], 1'b1};
                8'd12:   b = d.pts[14:7];
                8'd13:   b = {d.pts[6:0], 1'b1};
                default: b = 8'h00;
            endcase
        end
        else
        begin
            // ADTS header
            case (q)
                8'd0:    b = 8'hff;
                8'd1:    b = 8'hf9;
                8'd2:    b = {c.adts_profile, c.sample_rate_index, 1'b0,
                              c.channel_config[2]};
                8'd3:    b = {c.channel_config[1:0], 4'h0, d.fl[12:11]};
                8'd4:    b = d.fl[10:3];
                8'd5:    b = {d.fl[2:0], 5'h1f};
                8'd6:    b = 8'hfc;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    assign load      = !out_valid_reg || out_ready;
    assign advance   = head_valid && load;
    assign remaining = head.olen - pos_reg;
    assign fin       = (remaining <= 8'd8);
    assign cnt       = fin ? remaining[3:0] : 4'd8;
    assign pop       = advance && fin;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        bytes_next     = bytes_reg;
        count_next     = count_reg;
        pkt_end_next   = pkt_end_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = head_valid;
        end
        if (advance)
        begin
            for (int k = 0; k < 8; k++)
            begin
                bytes_next[8*k +: 8] = (4'(k) < cnt) ?
                    burst_byte(head, pos_reg + POS_W'(k), cfg) : 8'h00;
            end
            count_next   = cnt;
            last_next    = fin;
            pkt_end_next = fin && head.pkt_end;
            pos_next     = fin ? '0 : pos_reg + 8'd8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg   <= bytes_next;
        count_reg   <= count_next;
        pkt_end_reg <= pkt_end_next;
        last_reg    <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_bytes  = bytes_reg;
    assign byte_count = count_reg;
    assign packet_end = pkt_end_reg;
    assign last       = last_reg;

endmodule

[design/audio_ts_packetizer_core.sv]
// Top level of the audio transport stream packetiser: configuration
// registers, front end, descriptor queue and back end. Depends on atp_pkg.
//
// Audio frames arrive one byte per item; the first byte of a frame carries its
// length and a millisecond timestamp. Out come 188-byte MPEG-TS packets (PES
// header in the first packet, ADTS header in AAC mode, adaptation stuffing in
// the last), up to eight bytes per word, never across a packet edge. An item
// that adds only a payload byte becomes a one-byte burst; an item that opens a
// packet becomes a burst of header, stuffing and payload bytes, which the back
// end's word generator emits at one word per cycle while m_tready allows; the
// front end keeps accepting items while a queue of QUEUE_DEPTH bursts has
// room, so a header burst overlaps the arrival of following bytes.
module audio_ts_packetizer_core
    import atp_pkg::*;
#(
    parameter int QUEUE_DEPTH = ATP_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,  // data_byte, frame_len, timestamp_ms, zero pad
    input  logic                  s_tuser,  // frame_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata,  // out_bytes, byte_count, zero pad
    output logic                  m_tuser,  // packet_end
    output logic                  m_tlast
);

    cfg_t        cfg_reg;
    logic        push, pop, queue_full, queue_valid;
    desc_t       push_desc, head_desc;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pid               <= 13'd257;
            cfg_reg.codec_mode        <= 1'b0;
            cfg_reg.adts_profile      <= 2'd1;
            cfg_reg.sample_rate_index <= 4'd4;
            cfg_reg.channel_config    <= 3'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_PID:         cfg_reg.pid               <= cfg_wdata;
                CFG_CODEC_MODE:  cfg_reg.codec_mode        <= cfg_wdata[0];
                CFG_ADTS_PROF:   cfg_reg.adts_profile      <= cfg_wdata[1:0];
                CFG_SAMPLE_RATE: cfg_reg.sample_rate_index <= cfg_wdata[3:0];
                CFG_CHANNELS:    cfg_reg.channel_config    <= cfg_wdata[2:0];
                default:         ;
            endcase
        end
    end

    atp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .codec_mode   (cfg_reg.codec_mode),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .data_byte    (s_tdata[7:0]),
        .frame_start  (s_tuser),
        .frame_len    (s_tdata[20:8]),
        .timestamp_ms (s_tdata[52:21]),
        .queue_full   (queue_full),
        .push         (push),
        .desc         (push_desc)
    );

    atp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .pop       (pop),
        .head      (head_desc),
        .full      (queue_full),
        .not_empty (queue_valid)
    );

    atp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head_desc),
        .head_valid (queue_valid),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_bytes  (out_bytes),
        .byte_count (byte_count),
        .packet_end (m_tuser),
        .last       (m_tlast)
    );

    assign m_tdata = {4'h0, byte_count, out_bytes};

endmodule
